FILE: design/u8sd_pkg.sv
// Shared types, byte constants and the front-of-window decode function.
package u8sd_pkg;

   localparam int unsigned HoldDepth = 4;
   localparam int unsigned CpWidth   = 21;
   localparam int unsigned CntWidth  = 3;

   localparam logic [CpWidth-1:0] CP_REPLACEMENT = 21'h00FFFD;

   localparam logic [7:0] BYTE_ASCII_END = 8'h80;
   localparam logic [7:0] BYTE_LEAD_MIN  = 8'hC2;
   localparam logic [7:0] BYTE_LEAD_MAX  = 8'hF4;
   localparam logic [7:0] BYTE_LEAD2_MAX = 8'hDF;
   localparam logic [7:0] BYTE_LEAD3_MAX = 8'hEF;
   localparam logic [7:0] BYTE_E0        = 8'hE0;
   localparam logic [7:0] BYTE_ED        = 8'hED;
   localparam logic [7:0] BYTE_F0        = 8'hF0;
   localparam logic [7:0] BYTE_F4        = 8'hF4;
   localparam logic [7:0] SEC_E0_MIN     = 8'hA0;
   localparam logic [7:0] SEC_ED_MAX     = 8'h9F;
   localparam logic [7:0] SEC_F0_MIN     = 8'h90;
   localparam logic [7:0] SEC_F4_MAX     = 8'h8F;
   localparam logic [1:0] CONT_TAG       = 2'b10;

   typedef logic [HoldDepth-1:0][7:0] win_type;

   typedef struct packed {
      logic                ready;
      logic                err;
      logic [CntWidth-1:0] used;
      logic [CpWidth-1:0]  cp;
   } dec_type;

   typedef struct packed {
      logic load;
      logic consume;
   } u8sd_cmd_type;

   typedef struct packed {
      logic front_ready;
      logic is_last;
      logic out_free;
   } u8sd_sts_type;

   // Decode the sequence at the front of the window.
   function automatic dec_type u8sd_decode(input win_type win,
                                           input logic [CntWidth-1:0] count,
                                           input logic flush);
      logic [7:0]          b0;
      logic [7:0]          b1;
      logic [CntWidth-1:0] need;
      logic                bad;
      dec_type             r;
      int                  i;
      b0      = win[0];
      b1      = win[1];
      bad     = 1'b0;
      r.ready = 1'b1;
      r.err   = 1'b1;
      r.used  = 3'd1;
      r.cp    = CP_REPLACEMENT;
      if (b0 <= BYTE_LEAD2_MAX) begin
         need = 3'd2;
      end else if (b0 <= BYTE_LEAD3_MAX) begin
         need = 3'd3;
      end else begin
         need = 3'd4;
      end
      if (b0 < BYTE_ASCII_END) begin
         r.cp  = {13'd0, b0};
         r.err = 1'b0;
      end else if (b0 < BYTE_LEAD_MIN || b0 > BYTE_LEAD_MAX) begin
         r.err = 1'b1;
      end else if (count < need) begin
         // cut off: wait for more bytes unless the text ends here
         r.ready = flush;
      end else begin
         for (i = 1; i < HoldDepth; i++) begin
            if (3'(i) < need && win[i][7:6] != CONT_TAG) begin
               bad = 1'b1;
            end
         end
         if (b0 == BYTE_E0 && b1 < SEC_E0_MIN) bad = 1'b1;
         if (b0 == BYTE_ED && b1 > SEC_ED_MAX) bad = 1'b1;
         if (b0 == BYTE_F0 && b1 < SEC_F0_MIN) bad = 1'b1;
         if (b0 == BYTE_F4 && b1 > SEC_F4_MAX) bad = 1'b1;
         if (!bad) begin
            r.err  = 1'b0;
            r.used = need;
            if (need == 3'd2) begin
               r.cp = {10'd0, b0[4:0], b1[5:0]};
            end else if (need == 3'd3) begin
               r.cp = {5'd0, b0[3:0], b1[5:0], win[2][5:0]};
            end else begin
               r.cp = {b0[2:0], b1[5:0], win[2][5:0], win[3][5:0]};
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: design/u8sd_ctrl.sv
// Controller: accepts one word, then drains decoded results from the window.
module u8sd_ctrl import u8sd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  u8sd_sts_type sts,
   output u8sd_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.load    = 1'b0;
      cmd.consume = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!sts.front_ready) begin
               // front lead waits for more bytes
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.consume = 1'b1;
               if (sts.is_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/u8sd_dpath.sv
// Datapath: byte window, front decoder with lookahead, and result register.
module u8sd_dpath import u8sd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  u8sd_cmd_type        cmd,
   output u8sd_sts_type        sts,
   input  logic [7:0]          in_byte,
   input  logic                in_end,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [CpWidth-1:0]  out_cp,
   output logic [CntWidth-1:0] out_used,
   output logic                out_err,
   output logic                out_last,
   output logic                out_done
);

   win_type             held_ff;
   win_type             held_in;
   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;
   logic                flush_ff;
   logic                flush_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CpWidth-1:0]  cp_ff;
   logic [CntWidth-1:0] used_ff;
   logic                err_ff;
   logic                last_ff;
   logic                done_ff;

   dec_type             cur;
   dec_type             nxt;
   win_type             shifted;
   logic [CntWidth-1:0] remain;
   logic [CntWidth-1:0] idx;
   logic                last;

   // Decode the front, then look one result ahead on the shifted window.
   always_comb begin
      cur    = u8sd_decode(held_ff, count_ff, flush_ff);
      remain = count_ff - cur.used;
      for (int i = 0; i < HoldDepth; i++) begin
         idx = 3'(i) + cur.used;
         shifted[i] = (idx < 3'(HoldDepth)) ? held_ff[idx[1:0]] : 8'h00;
      end
      nxt  = u8sd_decode(shifted, remain, flush_ff);
      last = (remain == 3'd0) || !nxt.ready;
   end

   assign sts.front_ready = cur.ready;
   assign sts.is_last     = last;
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      if (cmd.load) begin
         held_in[count_ff[1:0]] = in_byte;
         count_in               = count_ff + 3'd1;
         flush_in               = in_end;
      end else if (cmd.consume) begin
         held_in  = shifted;
         count_in = remain;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.consume) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (cmd.consume) begin
         cp_ff   <= cur.cp;
         used_ff <= cur.used;
         err_ff  <= cur.err;
         last_ff <= last;
         done_ff <= last && flush_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_cp     = cp_ff;
   assign out_used   = used_ff;
   assign out_err    = err_ff;
   assign out_last   = last_ff;
   assign out_done   = done_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> count_ff < 3'(HoldDepth))
      else $error("byte loaded into a full window");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.consume && last && flush_ff) |=> count_ff == 3'd0)
      else $error("window not empty after end of text");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.consume |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

FILE: design/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder.
// Takes one UTF-8 byte per input word (req_tlast marks the final byte of a text)
// and returns one word per decoded code point. Each accepted byte is loaded
// into a four-byte window, and the results it releases (one to four) then
// leave one at a time, each held back while the result side stalls. A byte
// that releases nothing still takes the controller into its run state, in
// which it finds the front lead waiting. The controller takes no new byte
// until it has released every result the window can give at that point
// and has returned to idle.
// Bad lead bytes, missing continuation bytes, overlong forms, surrogates and
// values above U+10FFFF give U+FFFD with the error flag and consume only the
// lead byte; the bytes behind it are decoded again. A sequence still open when
// req_tlast arrives is flushed the same way, and the last result of that text
// has text_done set. rsp_tlast marks the last result released by one input byte.
module utf8_stream_decoder import u8sd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_point, [23:21] byte_count
   output logic        rsp_tlast,   // last_of_run
   output logic [1:0]  rsp_tuser    // [0] is_error, [1] text_done
);

   u8sd_cmd_type        cmd;
   u8sd_sts_type        sts;
   logic [CpWidth-1:0]  cp;
   logic [CntWidth-1:0] used;
   logic                err;
   logic                done;

   // Sequence the load and drain of the window.
   u8sd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the window, decode its front and register each result.
   u8sd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_cp     (cp),
      .out_used   (used),
      .out_err    (err),
      .out_last   (rsp_tlast),
      .out_done   (done)
   );

   // Pack the result word: code point low, byte count above it.
   assign rsp_tdata = {used, cp};
   assign rsp_tuser = {done, err};

endmodule
